[rtl/core/rpm_pkg.sv]
// Package for the randomized Prim maze carver: command and result beat
// types, operation codes, cell word bits and register indexes. No dependencies.
`timescale 1ns / 1ps

package rpm_pkg;

  localparam int COORD_W = 6;
  localparam int RAND_W  = 32;
  localparam int CFG_W   = 7;
  localparam int CELL_W  = 6;
  localparam int DIR_W   = 4;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [DIR_W-1:0] DIR_NONE = 4'd0;
  localparam logic [DIR_W-1:0] DIR_N    = 4'd1;
  localparam logic [DIR_W-1:0] DIR_S    = 4'd2;
  localparam logic [DIR_W-1:0] DIR_W4   = 4'd4;
  localparam logic [DIR_W-1:0] DIR_E    = 4'd8;

  localparam logic [CELL_W-1:0] BIT_MARKED = 6'd16;
  localparam logic [CELL_W-1:0] BIT_AVAIL  = 6'd32;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [RAND_W-1:0]  rand_a;
    logic [RAND_W-1:0]  rand_b;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] link_col;
    logic [COORD_W-1:0] link_row;
    logic [DIR_W-1:0]   link_dir;
    logic [CELL_W-1:0]  cell_bits;
    logic               frontier_empty;
    logic               error;
  } rsp_t;

endpackage

[rtl/core/rpm_mod.sv]
// Bit-serial remainder unit: dividend modulo divisor, one quotient bit a cycle.
// Depends on rpm_pkg for the dividend width.
`timescale 1ns / 1ps

module rpm_mod #(
  parameter int DW = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rpm_pkg::RAND_W-1:0] dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       done,
  output logic [DW-1:0]              rem
);

  localparam int CW = $clog2(rpm_pkg::RAND_W);

  logic                       running;
  logic [CW-1:0]              cnt;
  logic [rpm_pkg::RAND_W-1:0] sh;
  logic [DW-1:0]              dvs;
  logic [DW:0]                trial;
  logic [DW:0]                diff;

  assign trial = {rem, sh[rpm_pkg::RAND_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == CW'(rpm_pkg::RAND_W - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        sh      <= dividend;
        dvs     <= divisor;
        rem     <= '0;
      end else if (running) begin
        // Restoring step: keep the difference when it did not go negative.
        if (trial >= {1'b0, dvs}) begin
          rem <= diff[DW-1:0];
        end else begin
          rem <= trial[DW-1:0];
        end
        sh  <= sh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(rpm_pkg::RAND_W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/randomized_prim_maze_carver.sv]
// Top level of the randomized Prim maze carver: cell and frontier memories,
// the step sequencer and the configuration registers. Depends on rpm_pkg, rpm_mod.
//
// Usage: a command beat on cmd is taken at a clock edge where start is high
// and busy is low. Each command yields exactly one result beat on rsp, shown
// for one cycle with done high; the receiver cannot stall it.
// A read passes through S_RD_WAIT, where the registered cell word goes to rsp.
// A start runs a clearing pass over all MAX_COLS*MAX_ROWS cell words (one per
// cycle), then marks the start cell and adds its neighbors to the frontier.
// A step passes through the bit-serial remainder unit once, and again when the
// picked cell has a marked neighbor, and does up to seven single-port
// read-modify-writes of cell words. Rejected commands are answered in the
// cycle after they are taken. One command is worked on at a time. After reset
// busy stays high while the cell memory is cleared; configuration writes are
// taken at any time, and the grid size registers reset to 64 by 64.
`timescale 1ns / 1ps

module randomized_prim_maze_carver #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  rpm_pkg::cmd_t             cmd,
  output logic                      done,
  output rpm_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_addr,
  input  logic [rpm_pkg::CFG_W-1:0] cfg_data
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int TOPC  = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int TOPR  = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int CW    = rpm_pkg::COORD_W;
  localparam int XW    = CW + 1;
  localparam int FW    = 2 * CW;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_RD_WAIT = 5'd2;
  localparam logic [4:0] S_DIVA    = 5'd3;
  localparam logic [4:0] S_FL_RD1  = 5'd4;
  localparam logic [4:0] S_FL_RD2  = 5'd5;
  localparam logic [4:0] S_FL_WR   = 5'd6;
  localparam logic [4:0] S_NC_RD   = 5'd7;
  localparam logic [4:0] S_NC_CHK  = 5'd8;
  localparam logic [4:0] S_NC_END  = 5'd9;
  localparam logic [4:0] S_DIVB    = 5'd10;
  localparam logic [4:0] S_LNK_SET = 5'd11;
  localparam logic [4:0] S_LNK_RD1 = 5'd12;
  localparam logic [4:0] S_LNK_WR1 = 5'd13;
  localparam logic [4:0] S_LNK_RD2 = 5'd14;
  localparam logic [4:0] S_LNK_WR2 = 5'd15;
  localparam logic [4:0] S_MK_RD   = 5'd16;
  localparam logic [4:0] S_MK_WR   = 5'd17;
  localparam logic [4:0] S_NB_RD   = 5'd18;
  localparam logic [4:0] S_NB_WR   = 5'd19;
  localparam logic [4:0] S_FIN_RD  = 5'd20;
  localparam logic [4:0] S_FIN_OUT = 5'd21;

  logic [4:0] state;

  logic [rpm_pkg::CFG_W-1:0] grid_width;
  logic [rpm_pkg::CFG_W-1:0] grid_height;
  logic [XW-1:0]             w_eff;
  logic [XW-1:0]             h_eff;

  logic [rpm_pkg::CELL_W-1:0] cmem [CELLS];
  logic [AW-1:0]              c_addr;
  logic                       c_we;
  logic [rpm_pkg::CELL_W-1:0] c_wd;
  logic [rpm_pkg::CELL_W-1:0] c_q;

  logic [FW-1:0] fmem [CELLS];
  logic [AW-1:0] f_addr;
  logic          f_we;
  logic [FW-1:0] f_wd;
  logic [FW-1:0] f_q;

  logic                       boot;
  logic [AW-1:0]              clr_idx;
  logic [CNT_W-1:0]           count;
  logic [AW-1:0]              pick;
  logic [CW-1:0]              x;
  logic [CW-1:0]              y;
  logic [CW-1:0]              lx;
  logic [CW-1:0]              ly;
  logic [rpm_pkg::DIR_W-1:0]  dir;
  logic [1:0]                 k;
  logic [3:0]                 mask;
  logic [rpm_pkg::RAND_W-1:0] rand_b;

  logic                       div_start;
  logic [rpm_pkg::RAND_W-1:0] div_dividend;
  logic [CNT_W-1:0]           div_divisor;
  logic                       div_done;
  logic [CNT_W-1:0]           div_rem;

  logic [XW-1:0]             nx;
  logic [XW-1:0]             ny;
  logic                      nb_exists;
  logic                      add_ok;
  logic                      step_ok;
  logic [rpm_pkg::DIR_W-1:0] k_dir;
  logic [rpm_pkg::DIR_W-1:0] opp_dir;
  logic [2:0]                n_marked;
  logic [1:0]                sel_k;
  logic                      cmd_oob;
  logic                      accept;
  logic                      cmd_rej;
  logic                      done_next;
  rpm_pkg::rsp_t             rsp_idle;

  function automatic logic [AW-1:0] cidx(input logic [CW-1:0] cx, input logic [CW-1:0] cy);
    cidx = AW'(AW'(cy) * AW'(MAX_COLS)) + AW'(cx);
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Saturate the size registers into 1..min(MAX,64).
  always_comb begin
    if (grid_width == '0) begin
      w_eff = XW'(1);
    end else if (grid_width > XW'(TOPC)) begin
      w_eff = XW'(TOPC);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = XW'(1);
    end else if (grid_height > XW'(TOPR)) begin
      h_eff = XW'(TOPR);
    end else begin
      h_eff = grid_height;
    end
  end

  assign cmd_oob = ({1'b0, cmd.col} >= w_eff) || ({1'b0, cmd.row} >= h_eff);

  // A command is answered at once when it is a start or read out of range,
  // has an unused code, or is a step with an empty frontier.
  assign cmd_rej = !((((cmd.op == rpm_pkg::OP_START) || (cmd.op == rpm_pkg::OP_READ)) &&
                      !cmd_oob) ||
                     ((cmd.op == rpm_pkg::OP_STEP) && (count != '0)));

  always_comb begin
    rsp_idle                = '0;
    rsp_idle.frontier_empty = (count == '0);
    rsp_idle.error          = cmd_rej;
  end

  assign done_next = (accept && cmd_rej) || (state == S_RD_WAIT) || (state == S_FIN_OUT);

  // Neighbor k of the current cell in the order west, east, north, south.
  always_comb begin
    unique case (k)
      2'd0: begin
        nx        = {1'b0, x} - 1'b1;
        ny        = {1'b0, y};
        nb_exists = (x != '0);
        step_ok   = (x != '0);
        k_dir     = rpm_pkg::DIR_W4;
        opp_dir   = rpm_pkg::DIR_E;
      end
      2'd1: begin
        nx        = {1'b0, x} + 1'b1;
        ny        = {1'b0, y};
        nb_exists = 1'b1;
        step_ok   = (({1'b0, x} + 1'b1) < w_eff);
        k_dir     = rpm_pkg::DIR_E;
        opp_dir   = rpm_pkg::DIR_W4;
      end
      2'd2: begin
        nx        = {1'b0, x};
        ny        = {1'b0, y} - 1'b1;
        nb_exists = (y != '0);
        step_ok   = (y != '0);
        k_dir     = rpm_pkg::DIR_N;
        opp_dir   = rpm_pkg::DIR_S;
      end
      2'd3: begin
        nx        = {1'b0, x};
        ny        = {1'b0, y} + 1'b1;
        nb_exists = 1'b1;
        step_ok   = (({1'b0, y} + 1'b1) < h_eff);
        k_dir     = rpm_pkg::DIR_S;
        opp_dir   = rpm_pkg::DIR_N;
      end
      default: begin
        nx        = '0;
        ny        = '0;
        nb_exists = 1'b0;
        step_ok   = 1'b0;
        k_dir     = rpm_pkg::DIR_NONE;
        opp_dir   = rpm_pkg::DIR_NONE;
      end
    endcase
    add_ok = nb_exists && (nx < w_eff) && (ny < h_eff);
  end

  assign n_marked = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);

  // Position of the marked neighbor numbered by the second remainder.
  always_comb begin
    logic [2:0] seen;
    seen  = '0;
    sel_k = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == {1'b0, div_rem[1:0]}) begin
          sel_k = 2'(i);
        end
        seen = seen + 1'b1;
      end
    end
  end

  // Memory port control follows the sequencer state.
  always_comb begin
    c_addr = cidx(x, y);
    c_we   = 1'b0;
    c_wd   = c_q;
    f_addr = pick;
    f_we   = 1'b0;
    f_wd   = f_q;
    unique case (state)
      S_IDLE: begin
        c_addr = cidx(cmd.col, cmd.row);
      end
      S_CLR: begin
        c_addr = clr_idx;
        c_we   = 1'b1;
        c_wd   = '0;
      end
      S_FL_RD2: begin
        f_addr = AW'(count - 1'b1);
      end
      S_FL_WR: begin
        f_we = 1'b1;
      end
      S_NC_RD, S_NC_CHK, S_NB_RD: begin
        c_addr = cidx(nx[CW-1:0], ny[CW-1:0]);
      end
      S_NB_WR: begin
        c_addr = cidx(nx[CW-1:0], ny[CW-1:0]);
        f_addr = count[AW-1:0];
        f_wd   = {ny[CW-1:0], nx[CW-1:0]};
        if (c_q == '0 && count < CNT_W'(CELLS)) begin
          c_we = 1'b1;
          c_wd = rpm_pkg::BIT_AVAIL;
          f_we = 1'b1;
        end
      end
      S_LNK_WR1: begin
        c_we = 1'b1;
        c_wd = c_q | {2'b00, dir};
      end
      S_LNK_RD2: begin
        c_addr = cidx(lx, ly);
      end
      S_LNK_WR2: begin
        c_addr = cidx(lx, ly);
        c_we   = 1'b1;
        c_wd   = c_q | {2'b00, opp_dir};
      end
      S_MK_WR: begin
        c_we = 1'b1;
        c_wd = c_q | rpm_pkg::BIT_MARKED;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_addr] <= c_wd;
    end
    c_q <= cmem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_addr] <= f_wd;
    end
    f_q <= fmem[f_addr];
  end

  assign div_start    = (accept && cmd.op == rpm_pkg::OP_STEP && count != '0) ||
                        (state == S_NC_END && mask != '0);
  assign div_dividend = (state == S_IDLE) ? cmd.rand_a : rand_b;
  assign div_divisor  = (state == S_IDLE) ? count : CNT_W'(n_marked);

  rpm_mod #(
    .DW(CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= rpm_pkg::CFG_W'(64);
      grid_height <= rpm_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rpm_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        rpm_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      boot    <= 1'b1;
      clr_idx <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            x      <= cmd.col;
            y      <= cmd.row;
            rand_b <= cmd.rand_b;
            rsp    <= rsp_idle;
            priority if (cmd.op == rpm_pkg::OP_START && !cmd_oob) begin
              boot    <= 1'b0;
              clr_idx <= '0;
              lx      <= '0;
              ly      <= '0;
              dir     <= rpm_pkg::DIR_NONE;
              state   <= S_CLR;
            end else if (cmd.op == rpm_pkg::OP_READ && !cmd_oob) begin
              state <= S_RD_WAIT;
            end else if (cmd.op == rpm_pkg::OP_STEP && count != '0) begin
              state <= S_DIVA;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(CELLS - 1)) begin
            count <= '0;
            state <= boot ? S_IDLE : S_MK_RD;
          end
        end
        S_RD_WAIT: begin
          rsp.cell_col  <= x;
          rsp.cell_row  <= y;
          rsp.cell_bits <= c_q;
          state         <= S_IDLE;
        end
        S_DIVA: begin
          if (div_done) begin
            pick  <= div_rem[AW-1:0];
            state <= S_FL_RD1;
          end
        end
        S_FL_RD1: begin
          state <= S_FL_RD2;
        end
        S_FL_RD2: begin
          x     <= f_q[CW-1:0];
          y     <= f_q[FW-1:CW];
          state <= S_FL_WR;
        end
        S_FL_WR: begin
          // The last entry moves into the hole left by the picked one.
          count <= count - 1'b1;
          k     <= '0;
          mask  <= '0;
          state <= S_NC_RD;
        end
        S_NC_RD: begin
          if (step_ok) begin
            state <= S_NC_CHK;
          end else if (k == 2'd3) begin
            state <= S_NC_END;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_NC_CHK: begin
          mask[k] <= c_q[4];
          if (k == 2'd3) begin
            state <= S_NC_END;
          end else begin
            k     <= k + 1'b1;
            state <= S_NC_RD;
          end
        end
        S_NC_END: begin
          if (mask == '0) begin
            lx    <= x;
            ly    <= y;
            dir   <= rpm_pkg::DIR_NONE;
            state <= S_MK_RD;
          end else begin
            state <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            k     <= sel_k;
            state <= S_LNK_SET;
          end
        end
        S_LNK_SET: begin
          lx    <= nx[CW-1:0];
          ly    <= ny[CW-1:0];
          dir   <= k_dir;
          state <= S_LNK_RD1;
        end
        S_LNK_RD1: state <= S_LNK_WR1;
        S_LNK_WR1: state <= S_LNK_RD2;
        S_LNK_RD2: state <= S_LNK_WR2;
        S_LNK_WR2: state <= S_MK_RD;
        S_MK_RD:   state <= S_MK_WR;
        S_MK_WR: begin
          k     <= '0;
          state <= S_NB_RD;
        end
        S_NB_RD: begin
          if (add_ok) begin
            state <= S_NB_WR;
          end else if (k == 2'd3) begin
            state <= S_FIN_RD;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_NB_WR: begin
          if (c_q == '0 && count < CNT_W'(CELLS)) begin
            count <= count + 1'b1;
          end
          if (k == 2'd3) begin
            state <= S_FIN_RD;
          end else begin
            k     <= k + 1'b1;
            state <= S_NB_RD;
          end
        end
        S_FIN_RD: state <= S_FIN_OUT;
        S_FIN_OUT: begin
          rsp.cell_col       <= x;
          rsp.cell_row       <= y;
          rsp.link_col       <= lx;
          rsp.link_row       <= ly;
          rsp.link_dir       <= dir;
          rsp.cell_bits      <= c_q;
          rsp.frontier_empty <= (count == '0);
          rsp.error          <= 1'b0;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
